// ----- design/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the alphabet lookup of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int LENGTH_BITS    = 16;
  localparam int LIMIT_BITS     = 16;
  localparam int CMP_BITS       = (LENGTH_BITS > LIMIT_BITS) ? LENGTH_BITS : LIMIT_BITS;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_LIMIT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_ONLY   = CFG_INDEX_BITS'(1);

  localparam logic [7:0] CHAR_END = 8'h00;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADCHAR  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_BADPAD   = 3'd3,
    ST_LEFTOVER = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CK_END   = 3'd0,
    CK_WHITE = 3'd1,
    CK_PAD   = 3'd2,
    CK_DATA  = 3'd3,
    CK_BAD   = 3'd4
  } char_kind_e;

  typedef struct packed {
    char_kind_e  kind;
    logic [5:0]  sextet;
  } entry_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] output_limit;
    logic                  count_only;
  } cfg_t;

  function automatic entry_t classify(input logic [7:0] c);
    entry_t e;
    e.kind   = CK_BAD;
    e.sextet = 6'd0;
    if (c == CHAR_END) begin
      e.kind = CK_END;
    end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
      e.kind = CK_WHITE;
    end else if (c == CHAR_PAD) begin
      e.kind = CK_PAD;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      e.kind   = CK_DATA;
      e.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      e.kind   = CK_DATA;
      e.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      e.kind   = CK_DATA;
      e.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      e.kind   = CK_DATA;
      e.sextet = 6'd62;
    end else if (c == 8'h2F) begin
      e.kind   = CK_DATA;
      e.sextet = 6'd63;
    end
    return e;
  endfunction

endpackage

// ----- design/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, standard alphabet, one character per request.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while in_stall_o is low and returns
// at most one result per character: a decoded byte, or a report with length
// and status at the zero end character. Whitespace is dropped by the front
// classifier and yields nothing. Classified characters pass through a
// two-entry queue to the decode stage, which handles one entry per cycle
// while its result register is not stalled, into a registered result; the
// decode stage's single state update per entry sets the one-item-per-cycle
// rate. Configuration registers are to be written through the plain write
// port while the block is idle; the user is bound, the block does not enforce it.
module base64_stream_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [b64d_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [b64d_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           text_char_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 is_report_o,
  output logic [7:0]                           data_byte_o,
  output logic [15:0]                          decoded_length_o,
  output logic [2:0]                           status_o
);
  import b64d_pkg::*;

  cfg_t    cfg_q;
  logic    q_full, q_push, q_valid, q_pop;
  entry_t  push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.output_limit <= {LIMIT_BITS{1'b1}};
      cfg_q.count_only   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data_i[LIMIT_BITS-1:0];
        REG_COUNT_ONLY:   cfg_q.count_only   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  b64d_front u_front (
    .in_valid_i  (in_valid_i),
    .text_char_i (text_char_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  b64d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_entry_i        (head_entry),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_report_o      (is_report_o),
    .data_byte_o      (data_byte_o),
    .decoded_length_o (decoded_length_o),
    .status_o         (status_o)
  );

endmodule

// ----- design/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front
// Input side: takes characters, classifies them and drops whitespace.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic              in_valid_i,
  input  logic [7:0]        text_char_i,
  output logic              in_stall_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output b64d_pkg::entry_t  q_entry_o
);
  import b64d_pkg::*;

  entry_t cls;

  assign cls        = classify(text_char_i);
  assign in_stall_o = q_full_i;
  // whitespace never touches decoder state, so it is not queued at all
  assign q_push_o   = in_valid_i && !q_full_i && (cls.kind != CK_WHITE);
  assign q_entry_o  = cls;

endmodule

// ----- design/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue
// Short flop queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64d_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output b64d_pkg::entry_t  entry_o
);
  import b64d_pkg::*;

  entry_t                slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]  cnt_q, cnt_d;
  logic                  do_push, do_pop;

  function automatic logic [QPTR_BITS-1:0] ptr_next(input logic [QPTR_BITS-1:0] p);
    if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) return '0;
    return p + QPTR_BITS'(1);
  endfunction

  assign full_o  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- design/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back
// Decode side: quartet/padding state, byte assembly, limits and the result
// register.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64d_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  b64d_pkg::entry_t  q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              is_report_o,
  output logic [7:0]        data_byte_o,
  output logic [15:0]       decoded_length_o,
  output logic [2:0]        status_o
);
  import b64d_pkg::*;

  localparam logic [1:0] PAD_NONE  = 2'd0;
  localparam logic [1:0] PAD_WAIT2 = 2'd1;
  localparam logic [1:0] PAD_DONE  = 2'd2;

  logic [1:0]             phase_q, phase_d;
  logic [1:0]             pad_q, pad_d;
  logic [7:0]             partial_q, partial_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  status_e                err_q, err_d;

  logic                   out_valid_q;
  logic                   out_report_q;
  logic [7:0]             out_byte_q;
  logic [15:0]            out_len_q;
  logic [2:0]             out_status_q;

  logic                   advance, pop;
  logic                   emit, emit_report;
  logic [7:0]             emit_byte;
  logic [15:0]            emit_len;
  status_e                emit_status;
  logic                   beyond_limit, cnt_full;
  logic                   finish;
  logic [7:0]             byte_val;
  logic [5:0]             v;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop     = advance && q_valid_i;
  assign q_pop_o = pop;
  assign v       = q_entry_i.sextet;

  assign beyond_limit = !cfg_i.count_only &&
                        (CMP_BITS'(cnt_q) >= CMP_BITS'(cfg_i.output_limit));
  assign cnt_full     = (cnt_q == {LENGTH_BITS{1'b1}});

  always_comb begin
    phase_d     = phase_q;
    pad_d       = pad_q;
    partial_d   = partial_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    emit        = 1'b0;
    emit_report = 1'b0;
    emit_byte   = 8'd0;
    emit_len    = 16'(cnt_q);
    emit_status = ST_OK;
    finish      = 1'b0;
    byte_val    = 8'd0;

    if (pop) begin
      if (q_entry_i.kind == CK_END) begin
        emit        = 1'b1;
        emit_report = 1'b1;
        emit_status = err_q;
        if (err_q == ST_OK) begin
          if (pad_q == PAD_WAIT2) begin
            emit_status = ST_BADPAD;
          end else if (pad_q == PAD_NONE && phase_q != 2'd0) begin
            emit_status = ST_BADPAD;
          end else if (pad_q == PAD_DONE && partial_q != 8'd0) begin
            emit_status = ST_LEFTOVER;
          end
        end
        phase_d   = 2'd0;
        pad_d     = PAD_NONE;
        partial_d = 8'd0;
        cnt_d     = '0;
        err_d     = ST_OK;
      end else if (err_q != ST_OK) begin
        // swallowed until the end character
      end else if (pad_q == PAD_WAIT2) begin
        if (q_entry_i.kind == CK_PAD) pad_d = PAD_DONE;
        else err_d = ST_BADPAD;
      end else if (pad_q != PAD_NONE) begin
        err_d = ST_BADPAD;
      end else if (q_entry_i.kind == CK_PAD) begin
        if (phase_q == 2'd2) pad_d = PAD_WAIT2;
        else if (phase_q == 2'd3) pad_d = PAD_DONE;
        else err_d = ST_BADPAD;
      end else if (q_entry_i.kind != CK_DATA) begin
        err_d = ST_BADCHAR;
      end else begin
        unique case (phase_q)
          2'd0: begin
            if (beyond_limit) begin
              err_d = ST_OVERFLOW;
            end else begin
              partial_d = {v, 2'b00};
              phase_d   = 2'd1;
            end
          end
          2'd1: begin
            byte_val  = partial_q | {6'd0, v[5:4]};
            partial_d = {v[3:0], 4'd0};
            phase_d   = 2'd2;
            finish    = 1'b1;
          end
          2'd2: begin
            byte_val  = partial_q | {4'd0, v[5:2]};
            partial_d = {v[1:0], 6'd0};
            phase_d   = 2'd3;
            finish    = 1'b1;
          end
          default: begin
            byte_val  = partial_q | {2'd0, v};
            partial_d = 8'd0;
            phase_d   = 2'd0;
            finish    = 1'b1;
          end
        endcase
        if (finish) begin
          if (beyond_limit || cnt_full) begin
            err_d = ST_OVERFLOW;
          end else begin
            cnt_d     = cnt_q + LENGTH_BITS'(1);
            emit      = !cfg_i.count_only;
            emit_byte = byte_val;
            emit_len  = 16'(cnt_q + LENGTH_BITS'(1));
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 2'd0;
      pad_q       <= PAD_NONE;
      partial_q   <= 8'd0;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pad_q     <= pad_d;
      partial_q <= partial_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
      if (advance) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_report_q <= emit_report;
      out_byte_q   <= emit_byte;
      out_len_q    <= emit_len;
      out_status_q <= emit_status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_report_o      = out_report_q;
  assign data_byte_o      = out_byte_q;
  assign decoded_length_o = out_len_q;
  assign status_o         = out_status_q;

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && q_entry_i.kind == CK_END |=> cnt_q == '0 && err_q == ST_OK && phase_q == 2'd0)
    else $error("message state not cleared after end");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != ST_OK && !(pop && q_entry_i.kind == CK_END) |=> err_q == $past(err_q))
    else $error("error code changed before end");

  a_cnt_only_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_d != cnt_q |-> pop && (q_entry_i.kind == CK_END || q_entry_i.kind == CK_DATA))
    else $error("byte count moved without a data or end request");

  a_no_pop_while_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !q_pop_o)
    else $error("queue popped while result register is blocked");

endmodule
